// File: design/ssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int WIN_BYTES = 16;              // largest pattern / replacement
    localparam int LEN_W     = 5;               // holds 0..WIN_BYTES
    localparam int IDX_W     = 4;               // indexes WIN_BYTES bytes
    localparam int DATA_W    = WIN_BYTES * 8;
    localparam int CFG_W     = 64;

    typedef enum logic [2:0] {
        REG_PAT_LO   = 3'd0,
        REG_PAT_HI   = 3'd1,
        REG_PAT_LEN  = 3'd2,
        REG_REPL_LO  = 3'd3,
        REG_REPL_HI  = 3'd4,
        REG_REPL_LEN = 3'd5
    } t_cfg_reg;

    // Active configuration, lengths already clamped to their legal range
    typedef struct packed {
        logic [DATA_W-1:0] pattern;
        logic [LEN_W-1:0]  pat_len;
        logic [DATA_W-1:0] repl;
        logic [LEN_W-1:0]  repl_len;
    } t_cfg;

    // Emit command: send count bytes of data, byte 0 first; count 0 is a bare end
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  count;
        logic              last;
    } t_cmd;

endpackage

// File: design/ssr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_front
// Holds the pending window, compares it with the pattern and turns each
// transaction into at most one emit command.
// ----------------------------------------------------------------------------
module ssr_front import ssr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_fill_clr,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_byte_present,
    input  logic             i_end_of_text,
    input  logic             i_q_full,
    output logic             o_q_push,
    output t_cmd             o_q_cmd
);

    logic [7:0]        r_win [WIN_BYTES];
    logic [7:0]        n_win [WIN_BYTES];
    logic [7:0]        w_cur [WIN_BYTES];
    logic [LEN_W-1:0]  r_fill;
    logic [LEN_W-1:0]  n_fill;
    logic [LEN_W-1:0]  fill_eff;
    logic [LEN_W-1:0]  fill_new;
    logic [DATA_W-1:0] win_flat;
    logic              full;
    logic              match;
    logic              want_push;
    logic              accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = accept && want_push;

    always_comb begin
        fill_eff = (r_fill >= i_cfg.pat_len) ? '0 : r_fill;
        fill_new = fill_eff + LEN_W'(i_byte_present);

        // Window with the incoming byte placed behind the pending ones
        for (int i = 0; i < WIN_BYTES; i++) begin
            w_cur[i] = (LEN_W'(i) < fill_eff) ? r_win[i] : i_data_byte;
            win_flat[8*i +: 8] = w_cur[i];
        end

        match = 1'b1;
        for (int i = 0; i < WIN_BYTES; i++) begin
            if ((LEN_W'(i) < i_cfg.pat_len) && (w_cur[i] != i_cfg.pattern[8*i +: 8])) begin
                match = 1'b0;
            end
        end

        full = i_byte_present && (fill_new == i_cfg.pat_len);

        // Command: replacement on a match, else the window head (or all of it
        // on the end transaction, which covers the flush)
        o_q_cmd.last  = i_end_of_text;
        o_q_cmd.data  = win_flat;
        o_q_cmd.count = fill_new;
        want_push     = i_end_of_text;
        if (full && match) begin
            o_q_cmd.data  = i_cfg.repl;
            o_q_cmd.count = i_cfg.repl_len;
            want_push     = (i_cfg.repl_len != '0) || i_end_of_text;
        end else if (full && !i_end_of_text) begin
            o_q_cmd.count = LEN_W'(1);
            want_push     = 1'b1;
        end

        n_win  = w_cur;
        n_fill = fill_new;
        if (full) begin
            if (match) begin
                n_fill = '0;
            end else begin
                for (int i = 0; i < WIN_BYTES - 1; i++) begin
                    n_win[i] = w_cur[i+1];
                end
                n_fill = i_cfg.pat_len - LEN_W'(1);
            end
        end
        if (i_end_of_text) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_fill_clr) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

`ifndef SYNTHESIS
    // Pending count never reaches the pattern length
    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < i_cfg.pat_len)
        else $error("window fill reached pattern length");
`endif

endmodule

// File: design/ssr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ssr_cmd_fifo import ssr_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: design/ssr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_back
// Walks the head command byte by byte into the output register.
// ----------------------------------------------------------------------------
module ssr_back import ssr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_q_cmd,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_byte_present,
    output logic       o_last_of_run
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_present;
    logic             r_last;
    logic             load;
    logic             emit;
    logic             beat_last;

    assign load      = !r_valid || i_out_ready;
    assign emit      = load && !i_q_empty;
    assign beat_last = (i_q_cmd.count == '0) ||
                       ({1'b0, r_idx} == i_q_cmd.count - LEN_W'(1));
    assign o_q_pop   = emit && beat_last;

    assign o_out_valid        = r_valid;
    assign o_out_byte         = r_byte;
    assign o_out_byte_present = r_present;
    assign o_last_of_run      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_q_empty;
            end
            if (emit) begin
                r_idx <= beat_last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    // A bare end marker carries a zero byte
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte    <= (i_q_cmd.count != '0) ? i_q_cmd.data[{r_idx, 3'b000} +: 8] : 8'h00;
            r_present <= (i_q_cmd.count != '0);
            r_last    <= i_q_cmd.last && beat_last;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_empty && i_q_cmd.count != '0) |-> ({1'b0, r_idx} < i_q_cmd.count))
        else $error("byte index beyond command length");
    a_mid_cmd_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> !i_q_empty)
        else $error("partial command with empty queue");
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_present) |-> r_last)
        else $error("bare result without end mark");
`endif

endmodule

// File: design/stream_substring_replace.sv
`timescale 1ns / 1ps
// A transaction's command is written into the command queue; its first result is then loaded into the output register.
// Throughput: one input transaction per cycle while each causes at most one result and the output is not stalled.
// A transaction causing k results (replacement burst or end flush, k up to 16)
// holds the output side while its bytes go out one by one; the 2-entry command queue then fills and
// input ready drops until the burst drains.
// Reset (synchronous, active low): window empty, queue and output empty, config defaults.
// ----------------------------------------------------------------------------
// stream_substring_replace
// Streaming find-and-replace on a byte stream: every leftmost, non-overlapping
// occurrence of the pattern is replaced by the replacement bytes.
// ----------------------------------------------------------------------------
module stream_substring_replace import ssr_pkg::*; #(
    parameter int CMD_FIFO_DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_wr_en,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // input stream
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_byte_present,
    input  logic             i_end_of_text,
    // output stream
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_byte_present,
    output logic             o_last_of_run
);

    // Configuration registers, raw as written
    logic [CFG_W-1:0] r_pat_lo;
    logic [CFG_W-1:0] r_pat_hi;
    logic [LEN_W-1:0] r_pat_len;
    logic [CFG_W-1:0] r_repl_lo;
    logic [CFG_W-1:0] r_repl_hi;
    logic [LEN_W-1:0] r_repl_len;
    logic             fill_clr;
    t_cfg             cfg;

    t_cmd             q_in_cmd;
    t_cmd             q_out_cmd;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo   <= '0;
            r_pat_hi   <= '0;
            r_pat_len  <= LEN_W'(1);
            r_repl_lo  <= '0;
            r_repl_hi  <= '0;
            r_repl_len <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PAT_LO:   r_pat_lo   <= i_cfg_wdata;
                REG_PAT_HI:   r_pat_hi   <= i_cfg_wdata;
                REG_PAT_LEN:  r_pat_len  <= i_cfg_wdata[LEN_W-1:0];
                REG_REPL_LO:  r_repl_lo  <= i_cfg_wdata;
                REG_REPL_HI:  r_repl_hi  <= i_cfg_wdata;
                REG_REPL_LEN: r_repl_len <= i_cfg_wdata[LEN_W-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // A new pattern length discards the pending window
    assign fill_clr = i_cfg_wr_en && (i_cfg_index == REG_PAT_LEN);

    // Clamp lengths: an empty pattern acts as one byte, both cap at the window size
    always_comb begin
        cfg.pattern = {r_pat_hi, r_pat_lo};
        cfg.repl    = {r_repl_hi, r_repl_lo};
        if (r_pat_len == '0) begin
            cfg.pat_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(WIN_BYTES)) begin
            cfg.pat_len = LEN_W'(WIN_BYTES);
        end else begin
            cfg.pat_len = r_pat_len;
        end
        cfg.repl_len = (r_repl_len > LEN_W'(WIN_BYTES)) ? LEN_W'(WIN_BYTES) : r_repl_len;
    end

    // Front: window, compare, one command per transaction
    ssr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_fill_clr     (fill_clr),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_text  (i_end_of_text),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in_cmd)
    );

    // Queue: decouple the front from output stalls and bursts
    ssr_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    // Back: one output byte per cycle from the head command while the output is ready
    ssr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_cmd            (q_out_cmd),
        .i_q_empty          (q_empty),
        .o_q_pop            (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_out_byte_present (o_out_byte_present),
        .o_last_of_run      (o_last_of_run)
    );

endmodule
